// ===== rtl/core/mme_pkg.sv =====
package mme_pkg;

  localparam int unsigned ResW    = 30;
  localparam int unsigned ExpBits = 63;
  localparam int unsigned CntW    = $clog2(ResW);

  localparam logic [ResW-1:0] Prime = ResW'(1000000007);
  localparam logic [CntW-1:0] LastStep = CntW'(ResW - 1);

  typedef struct packed {
    logic            start;
    logic [ResW-1:0] mcand;
    logic [ResW-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [ResW-1:0] product;
  } mul_rsp_t;

endpackage

// ===== rtl/core/mme_modmul.sv =====
module mme_modmul
  import mme_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ResW-1:0] mcand_q, mcand_d;
  logic [ResW-1:0] mplier_q, mplier_d;
  logic [ResW-1:0] r_q, r_d;

  logic [ResW:0]   dbl;
  logic [ResW:0]   dbl_red;
  logic [ResW:0]   sum;
  logic [ResW:0]   sum_red;
  logic [ResW-1:0] addend;

  // Interleaved multiply: double, add the multiplicand on a set bit, reduce each time.
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, Prime}) ? dbl - {1'b0, Prime} : dbl;
    addend  = mplier_q[ResW-1] ? mcand_q : '0;
    sum     = {1'b0, dbl_red[ResW-1:0]} + {1'b0, addend};
    sum_red = (sum >= {1'b0, Prime}) ? sum - {1'b0, Prime} : sum;
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    r_d      = r_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      r_d      = '0;
    end else if (busy_q) begin
      r_d      = sum_red[ResW-1:0];
      mplier_d = {mplier_q[ResW-2:0], 1'b0};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    r_q      <= r_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = r_q;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation: power_result_o = base_value_i ^ exponent_i mod 1000000007.
//
// Input channel: in_valid_i / in_stall_o carry base_value_i and exponent_i; a beat
// is taken when in_valid_i is high and in_stall_o is low. Output channel:
// out_valid_o / out_stall_i carry power_result_o, one result beat per input beat.
//
// The exponent is scanned from its lowest bit. For each bit two bit-serial modular
// multipliers run side by side, one squaring the running base and one multiplying
// the accumulator by it; each takes one multiplier bit per cycle, and each bit goes
// through a start state, the multiplier steps and a write-back. The scan stops
// after the highest set bit, and a zero exponent goes straight to the finish state.
// One beat is worked on at a time, so the next beat is taken only once the last is
// through; in_stall_o stays high until its result has been moved into the output
// register, which holds it while out_stall_i is high. The next beat may be taken
// while that result still waits.
//
// Reset is asynchronous and active low; it empties the output register and
// returns the sequencer to idle. No clearing pass is needed.
module modular_exponentiation
  import mme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ResW-1:0]    base_value_i,
  input  logic [ExpBits-1:0] exponent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ResW-1:0]    power_result_o
);

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StWait,
    StFinish
  } state_e;

  state_e             state_q, state_d;
  logic [ResW-1:0]    base_q, base_d;
  logic [ResW-1:0]    acc_q, acc_d;
  logic [ExpBits-1:0] exp_q, exp_d;
  logic [ExpBits-1:0] exp_next;
  logic               out_valid_q, out_valid_d;
  logic [ResW-1:0]    out_q, out_d;
  logic               in_take;
  logic               out_free;

  mul_req_t sq_req, mu_req;
  mul_rsp_t sq_rsp, mu_rsp;

  mme_modmul u_square (
    .clk_i,
    .rst_ni,
    .req_i (sq_req),
    .rsp_o (sq_rsp)
  );

  mme_modmul u_mult (
    .clk_i,
    .rst_ni,
    .req_i (mu_req),
    .rsp_o (mu_rsp)
  );

  assign in_take  = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign exp_next = exp_q >> 1;

  always_comb begin
    sq_req.start  = (state_q == StStart);
    sq_req.mcand  = base_q;
    sq_req.mplier = base_q;
    mu_req.start  = (state_q == StStart);
    mu_req.mcand  = acc_q;
    mu_req.mplier = base_q;
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    acc_d       = acc_q;
    exp_d       = exp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          // fold an unreduced base once; it stays below twice the prime
          base_d  = (base_value_i >= Prime) ? base_value_i - Prime : base_value_i;
          acc_d   = ResW'(1);
          exp_d   = exponent_i;
          state_d = (exponent_i == '0) ? StFinish : StStart;
        end
      end
      StStart: begin
        state_d = StWait;
      end
      StWait: begin
        if (sq_rsp.done && mu_rsp.done) begin
          if (exp_q[0]) begin
            acc_d = mu_rsp.product;
          end
          base_d  = sq_rsp.product;
          exp_d   = exp_next;
          state_d = (exp_next == '0) ? StFinish : StStart;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
    out_q  <= out_d;
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

endmodule

// ===== rtl/core/mme_checker.sv =====
module mme_checker
  import mme_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [ResW-1:0]    base_value_i,
  input logic [ExpBits-1:0] exponent_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ResW-1:0]    power_result_o
);

  // a result is always a proper residue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (power_result_o < Prime))
    else $error("result not reduced");

  // one beat in flight: stall rises right after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a zero exponent with a free output slot yields a result of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (exponent_i == '0) && !out_valid_o)
      |-> ##2 (out_valid_o && (power_result_o == ResW'(1))))
    else $error("zero exponent result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(power_result_o)))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation mme_checker u_mme_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import mme_pkg::*;
;

  localparam longint unsigned PrimeMod  = 64'd1000000007;
  localparam int unsigned     NumRandom = 1530;
  localparam int unsigned     HoldLong  = 2500;
  localparam int unsigned     TailWait  = 2100;

  class power_scoreboard;
    logic [ResW-1:0] pending_powers[$];
    int unsigned     failures;

    function new();
      failures = 0;
    endfunction

    // Right-to-left square-and-multiply over every exponent bit.
    function logic [ResW-1:0] expected_power(logic [ResW-1:0] base_in,
                                             logic [ExpBits-1:0] exp_in);
      longint unsigned acc;
      longint unsigned run_base;
      acc      = 64'd1;
      run_base = 64'(base_in) % PrimeMod;
      for (int i = 0; i < ExpBits; i++) begin
        if (exp_in[i]) acc = (acc * run_base) % PrimeMod;
        run_base = (run_base * run_base) % PrimeMod;
      end
      return acc[ResW-1:0];
    endfunction

    function void note_operands(logic [ResW-1:0] base_in, logic [ExpBits-1:0] exp_in);
      logic [ResW-1:0] want;
      want           = expected_power(base_in, exp_in);
      pending_powers = {pending_powers, want};
    endfunction

    function void check_power(logic [ResW-1:0] got);
      logic [ResW-1:0] want;
      if (pending_powers.size() == 0) begin
        $error("power_result: no beat pending, expected none, actual %0d", got);
        failures++;
      end else begin
        want = pending_powers.pop_front();
        if (got !== want) begin
          $error("power_result: expected %0d, actual %0d", want, got);
          failures++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_powers.size();
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [ResW-1:0]    base_value_i   = '0;
  logic [ExpBits-1:0] exponent_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [ResW-1:0]    power_result_o;

  power_scoreboard sb = new();
  int unsigned     burst_left = 0;
  bit              long_hold_due = 1'b0;

  modular_exponentiation dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_o (power_result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_operands(base_value_i, exponent_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_power(power_result_o);
  end

  task automatic offer_operands(input logic [ResW-1:0] base_in,
                                input logic [ExpBits-1:0] exp_in);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    base_value_i <= base_in;
    exponent_i   <= exp_in;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the sender until every pending beat has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic offer_random();
    logic [ResW-1:0] base_pick;
    longint unsigned raw_exp;
    longint unsigned exp_mask;
    int unsigned     pick;
    int unsigned     width;
    pick = $urandom_range(0, 19);
    if (pick == 0)      base_pick = '0;
    else if (pick == 1) base_pick = Prime - 1'b1;
    else if (pick == 2) base_pick = ResW'($urandom_range(1000000007, 1073741823));
    else                base_pick = ResW'($urandom());
    // Keep most exponents short; the scan time grows with the top set bit.
    pick = $urandom_range(0, 99);
    if (pick < 80)      width = $urandom_range(0, 10);
    else if (pick < 95) width = $urandom_range(11, 32);
    else                width = $urandom_range(33, ExpBits);
    raw_exp  = {$urandom(), $urandom()};
    exp_mask = (64'd1 << width) - 64'd1;
    offer_operands(base_pick, ExpBits'(raw_exp & exp_mask));
  endtask

  initial begin
    logic [ExpBits-1:0] all_ones;
    all_ones = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_operands('0, '0);
    offer_operands('0, 63'd1);
    offer_operands(30'd1, all_ones);
    offer_operands(Prime - 1'b1, '0);
    offer_operands(Prime - 1'b1, 63'd1);
    offer_operands(Prime - 1'b1, 63'd2);
    offer_operands(Prime - 1'b1, all_ones);
    offer_operands('1, '0);
    offer_operands('1, 63'd1);
    offer_operands('1, 63'd5);
    offer_operands('1, all_ones);
    offer_operands(Prime, '0);
    offer_operands(Prime, 63'd3);
    offer_operands(Prime + 1'b1, 63'd7);
    offer_operands(30'd2, 63'd1000000006);
    offer_operands(30'd2, 63'h4000_0000_0000_0000);
    offer_operands(30'd12345, all_ones);
    offer_operands(30'h2AAA_AAAA, 63'h5555_5555_5555_5555);
    offer_operands(Prime - 1'b1, 63'h2AAA_AAAA_AAAA_AAAA);
    offer_operands(30'h1555_5555, 63'h7FFF_FFFF_0000_0001);
    wait_for_drain();

    long_hold_due = 1'b1;
    for (int n = 1; n <= NumRandom; n++) begin
      offer_random();
      if (n % 400 == 0) wait_for_drain();
    end
    wait_for_drain();
    repeat (TailWait) @(posedge clk_i);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 499);
      len  = $urandom_range(1, 60);
      if (long_hold_due || pick == 0) begin
        long_hold_due = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldLong) @(posedge clk_i);
      end else if (pick < 150) begin
        out_stall_i <= 1'b0;
        repeat (len) @(posedge clk_i);
      end else begin
        repeat (len) begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
